// File: rtl/gcma_pkg.sv
// Shared types and constants for the gravity-compensated motion accel block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package gcma_pkg;

   // Fixed-point formats
   localparam int QUAT_FRAC_BITS = 30;
   localparam int MUL_W = 35;              // multiplier operand width
   localparam int PROD_W = 2 * MUL_W;      // multiplier product width
   localparam int DIV_STEPS = 54;          // quotient bits per axis
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Input item
   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic [15:0]        step_time_us;
   } req_data_type;

   // Result item
   typedef struct packed {
      logic signed [31:0] motion_body_x;
      logic signed [31:0] motion_body_y;
      logic signed [31:0] motion_body_z;
      logic signed [31:0] motion_earth_x;
      logic signed [31:0] motion_earth_y;
      logic signed [31:0] motion_earth_z;
   } rsp_data_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP     = 4'd0,
      OP_LOAD    = 4'd1,
      OP_QPROD   = 4'd2,
      OP_ELEM    = 4'd3,
      OP_GRAV    = 4'd4,
      OP_NUMDT   = 4'd5,
      OP_NUMTAU  = 4'd6,
      OP_DIVINIT = 4'd7,
      OP_DIVSTEP = 4'd8,
      OP_SAVE    = 4'd9,
      OP_ROT     = 4'd10,
      OP_OUT     = 4'd11
   } op_type;

   // Command from controller to datapath
   typedef struct packed {
      op_type     op;
      logic       wb;     // write-back phase of a multiply
      logic [1:0] row;
      logic [1:0] col;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic den_zero;
      logic out_full;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/gcma_ctrl.sv
// Sequencer for the motion accel datapath: steps through the quaternion
// products, gravity removal, per-axis filter division and back rotation.
// Depends on gcma_pkg.
`default_nettype none

module gcma_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  gcma_pkg::status_type status,
   output gcma_pkg::cmd_type    cmd
);
   import gcma_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_QPROD   = 11'b000_0000_0010,
      S_ELEM    = 11'b000_0000_0100,
      S_GRAV    = 11'b000_0000_1000,
      S_NUMDT   = 11'b000_0001_0000,
      S_NUMTAU  = 11'b000_0010_0000,
      S_DIVINIT = 11'b000_0100_0000,
      S_DIV     = 11'b000_1000_0000,
      S_SAVE    = 11'b001_0000_0000,
      S_ROT     = 11'b010_0000_0000,
      S_OUT     = 11'b100_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             row_ff, row_in;
   logic [1:0]             col_ff, col_in;
   logic                   phase_ff, phase_in;
   logic [DIV_CNT_W-1:0]   div_ff, div_in;
   logic                   last_rc;

   assign last_rc = (row_ff == 2'd2) && (col_ff == 2'd2);

   // Next state and command
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      phase_in  = phase_ff;
      div_in    = div_ff;
      req_stall = 1'b1;
      cmd.op    = OP_NOP;
      cmd.wb    = phase_ff;
      cmd.row   = row_ff;
      cmd.col   = col_ff;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_QPROD;
               row_in   = 2'd0;
               col_in   = 2'd0;
               phase_in = 1'b0;
            end
         end
         S_QPROD, S_ROT: begin
            cmd.op   = (state_ff == S_QPROD) ? OP_QPROD : OP_ROT;
            phase_in = ~phase_ff;
            if (phase_ff) begin
               if (last_rc) begin
                  state_in = (state_ff == S_QPROD) ? S_ELEM : S_OUT;
               end else if (col_ff == 2'd2) begin
                  col_in = 2'd0;
                  row_in = row_ff + 2'd1;
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end
         end
         S_ELEM: begin
            cmd.op   = OP_ELEM;
            state_in = S_GRAV;
            row_in   = 2'd0;
            phase_in = 1'b0;
         end
         S_GRAV: begin
            cmd.op   = OP_GRAV;
            phase_in = ~phase_ff;
            if (phase_ff) begin
               if (row_ff == 2'd2) begin
                  row_in   = 2'd0;
                  col_in   = 2'd0;
                  state_in = status.den_zero ? S_ROT : S_NUMDT;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end
         end
         S_NUMDT: begin
            cmd.op   = OP_NUMDT;
            phase_in = ~phase_ff;
            if (phase_ff) state_in = S_NUMTAU;
         end
         S_NUMTAU: begin
            cmd.op   = OP_NUMTAU;
            phase_in = ~phase_ff;
            if (phase_ff) state_in = S_DIVINIT;
         end
         S_DIVINIT: begin
            cmd.op   = OP_DIVINIT;
            div_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIVSTEP;
            if (div_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_SAVE;
            end else begin
               div_in = div_ff + DIV_CNT_W'(1);
            end
         end
         S_SAVE: begin
            cmd.op = OP_SAVE;
            if (row_ff == 2'd2) begin
               row_in   = 2'd0;
               col_in   = 2'd0;
               state_in = S_ROT;
            end else begin
               row_in   = row_ff + 2'd1;
               state_in = S_NUMDT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!status.out_full) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
         phase_ff <= 1'b0;
         div_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
         div_ff   <= div_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/gcma_dpath.sv
// Datapath: shared multiplier, rotation matrix store, filter state, restoring
// divider and output register. Driven by gcma_ctrl commands; depends on gcma_pkg.
`default_nettype none

module gcma_dpath (
   input  wire                     clock,
   input  wire                     reset,
   input  gcma_pkg::cmd_type       cmd,
   input  gcma_pkg::req_data_type  req_data,
   input  wire [19:0]              tau,
   input  wire [20:0]              grav,
   input  wire                     rsp_stall,
   output logic                    rsp_valid,
   output gcma_pkg::rsp_data_type  rsp_data,
   output gcma_pkg::status_type    status
);
   import gcma_pkg::*;

   localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(1) << (QUAT_FRAC_BITS - 1);
   localparam logic signed [36:0] ONE_Q = 37'sd1 << QUAT_FRAC_BITS;
   localparam logic signed [36:0] ELEM_LIM = 37'sd1 << (QUAT_FRAC_BITS + 1);
   localparam logic signed [36:0] S32_MAX37 = 37'sd2147483647;
   localparam logic signed [36:0] S32_MIN37 = -37'sd2147483648;
   localparam logic [53:0] POS_LIM = 54'd2147483647;
   localparam logic [53:0] NEG_LIM = 54'd2147483648;

   function automatic logic signed [PROD_W-1:0] rnd_q(input logic signed [PROD_W-1:0] p);
      return (p + HALF_Q) >>> QUAT_FRAC_BITS;
   endfunction

   function automatic logic signed [32:0] clamp_elem(input logic signed [36:0] v);
      logic signed [36:0] c;
      c = (v > ELEM_LIM) ? ELEM_LIM : ((v < -ELEM_LIM) ? -ELEM_LIM : v);
      return c[32:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [36:0] c;
      c = (v > S32_MAX37) ? S32_MAX37 : ((v < S32_MIN37) ? S32_MIN37 : v);
      return c[31:0];
   endfunction

   function automatic logic signed [36:0] ext_qp(input logic signed [33:0] v);
      return {{3{v[33]}}, v};
   endfunction

   // Item registers
   logic signed [31:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [31:0] acc_ff [3];
   logic [15:0]        dt_ff;
   logic [20:0]        den_ff;

   // Quaternion products: xx yy zz xy xz yz wx wy wz
   logic signed [33:0] qp_ff [9];
   logic signed [32:0] elem_ff [9];
   logic signed [33:0] diff_ff [3];
   logic signed [31:0] fb_ff [3];
   logic signed [31:0] earth_ff [3];
   logic signed [36:0] sum_ff;
   logic signed [53:0] num_ff;
   logic [53:0]        quot_ff;
   logic [20:0]        rem_ff;
   logic               neg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;

   logic [3:0]          k;
   logic [3:0]          eidx;
   logic signed [32:0]  esel;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [36:0]  sum_in;
   logic signed [36:0]  e_raw [9];
   logic [21:0]         trial;
   logic [53:0]         mag;

   assign k    = ({2'b00, cmd.row} << 1) + {2'b00, cmd.row} + {2'b00, cmd.col};
   assign eidx = (cmd.op == OP_GRAV) ? (4'd6 + {2'b00, cmd.row}) : k;
   assign esel = elem_ff[eidx];

   // Select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_QPROD: begin
            case (k)
               4'd0: begin mul_a = MUL_W'(qx_ff); mul_b = MUL_W'(qx_ff); end
               4'd1: begin mul_a = MUL_W'(qy_ff); mul_b = MUL_W'(qy_ff); end
               4'd2: begin mul_a = MUL_W'(qz_ff); mul_b = MUL_W'(qz_ff); end
               4'd3: begin mul_a = MUL_W'(qx_ff); mul_b = MUL_W'(qy_ff); end
               4'd4: begin mul_a = MUL_W'(qx_ff); mul_b = MUL_W'(qz_ff); end
               4'd5: begin mul_a = MUL_W'(qy_ff); mul_b = MUL_W'(qz_ff); end
               4'd6: begin mul_a = MUL_W'(qw_ff); mul_b = MUL_W'(qx_ff); end
               4'd7: begin mul_a = MUL_W'(qw_ff); mul_b = MUL_W'(qy_ff); end
               4'd8: begin mul_a = MUL_W'(qw_ff); mul_b = MUL_W'(qz_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         OP_GRAV: begin
            mul_a = MUL_W'(esel);
            mul_b = $signed({14'b0, grav});
         end
         OP_NUMDT: begin
            mul_a = MUL_W'(diff_ff[cmd.row]);
            mul_b = $signed({19'b0, dt_ff});
         end
         OP_NUMTAU: begin
            mul_a = MUL_W'(fb_ff[cmd.row]);
            mul_b = $signed({15'b0, tau});
         end
         OP_ROT: begin
            mul_a = MUL_W'(esel);
            mul_b = MUL_W'(fb_ff[cmd.col]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_rnd = rnd_q(prod_ff);
   assign sum_in   = ((cmd.col == 2'd0) ? 37'sd0 : sum_ff) + prod_rnd[36:0];

   // Rotation matrix elements from the quaternion products
   always_comb begin
      e_raw[0] = ONE_Q - ((ext_qp(qp_ff[1]) + ext_qp(qp_ff[2])) <<< 1);
      e_raw[1] = (ext_qp(qp_ff[3]) - ext_qp(qp_ff[8])) <<< 1;
      e_raw[2] = (ext_qp(qp_ff[4]) + ext_qp(qp_ff[7])) <<< 1;
      e_raw[3] = (ext_qp(qp_ff[3]) + ext_qp(qp_ff[8])) <<< 1;
      e_raw[4] = ONE_Q - ((ext_qp(qp_ff[0]) + ext_qp(qp_ff[2])) <<< 1);
      e_raw[5] = (ext_qp(qp_ff[5]) - ext_qp(qp_ff[6])) <<< 1;
      e_raw[6] = (ext_qp(qp_ff[4]) - ext_qp(qp_ff[7])) <<< 1;
      e_raw[7] = (ext_qp(qp_ff[5]) + ext_qp(qp_ff[6])) <<< 1;
      e_raw[8] = ONE_Q - ((ext_qp(qp_ff[0]) + ext_qp(qp_ff[1])) <<< 1);
   end

   // Divider step and rounded magnitude
   assign trial = {rem_ff, quot_ff[53]};
   assign mag   = (num_ff[53] ? $unsigned(-num_ff) : $unsigned(num_ff))
                  + {34'b0, den_ff[20:1]};

   // Payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.op)
         OP_LOAD: begin
            qw_ff     <= req_data.quat_w;
            qx_ff     <= req_data.quat_x;
            qy_ff     <= req_data.quat_y;
            qz_ff     <= req_data.quat_z;
            acc_ff[0] <= req_data.accel_x;
            acc_ff[1] <= req_data.accel_y;
            acc_ff[2] <= req_data.accel_z;
            dt_ff     <= req_data.step_time_us;
            den_ff    <= {1'b0, tau} + {5'b0, req_data.step_time_us};
         end
         OP_QPROD: begin
            if (cmd.wb) qp_ff[k] <= prod_rnd[33:0];
         end
         OP_ELEM: begin
            for (int i = 0; i < 9; i++) elem_ff[i] <= clamp_elem(e_raw[i]);
         end
         OP_GRAV: begin
            if (cmd.wb) begin
               diff_ff[cmd.row] <= {acc_ff[cmd.row][31], acc_ff[cmd.row][31],
                                    acc_ff[cmd.row]} - prod_rnd[33:0];
            end
         end
         OP_NUMDT: begin
            if (cmd.wb) num_ff <= prod_ff[53:0];
         end
         OP_NUMTAU: begin
            if (cmd.wb) num_ff <= num_ff + prod_ff[53:0];
         end
         OP_DIVINIT: begin
            neg_ff  <= num_ff[53];
            quot_ff <= mag;
            rem_ff  <= '0;
         end
         OP_DIVSTEP: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_ff  <= 21'(trial - {1'b0, den_ff});
               quot_ff <= {quot_ff[52:0], 1'b1};
            end else begin
               rem_ff  <= trial[20:0];
               quot_ff <= {quot_ff[52:0], 1'b0};
            end
         end
         OP_ROT: begin
            if (cmd.wb) begin
               sum_ff <= sum_in;
               if (cmd.col == 2'd2) earth_ff[cmd.row] <= sat32(sum_in);
            end
         end
         default: begin
         end
      endcase
   end

   // Filter state: cleared at reset, written once per axis
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) fb_ff[i] <= '0;
      end else if (cmd.op == OP_SAVE) begin
         if (neg_ff) begin
            fb_ff[cmd.row] <= (quot_ff > NEG_LIM) ? 32'sh8000_0000
                                                   : 32'(-$signed(quot_ff));
         end else begin
            fb_ff[cmd.row] <= (quot_ff > POS_LIM) ? 32'sh7fff_ffff
                                                   : $signed(quot_ff[31:0]);
         end
      end
   end

   // Output register: load wins over a transfer in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_data_ff.motion_body_x  <= fb_ff[0];
         rsp_data_ff.motion_body_y  <= fb_ff[1];
         rsp_data_ff.motion_body_z  <= fb_ff[2];
         rsp_data_ff.motion_earth_x <= earth_ff[0];
         rsp_data_ff.motion_earth_y <= earth_ff[1];
         rsp_data_ff.motion_earth_z <= earth_ff[2];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.den_zero = (den_ff == 21'd0);
   assign status.out_full = rsp_valid_ff && rsp_stall;

endmodule

`default_nettype wire

// File: rtl/gravity_compensated_motion_accel.sv
// Top level: configuration registers, sequencer and datapath.
// Depends on gcma_pkg, gcma_ctrl and gcma_dpath.
//
// Removes gravity from a body-frame accelerometer sample using the attitude
// quaternion, low-pass filters the result per axis and rotates it back to the
// earth frame. One item is processed at a time on a single shared 35x35
// multiplier and a one-bit-per-cycle restoring divider: an item goes through
// the quaternion products, the matrix elements, gravity removal, per axis the
// filter numerator and the divider steps, then the rotation and the output;
// the filter is skipped when tau plus dt is zero and the filter state is held.
// The next item is taken while a finished result still waits in the output
// register. Registers: 0x0 filter time constant (us), 0x4 gravity level.
`default_nettype none

module gravity_compensated_motion_accel (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  gcma_pkg::req_data_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output gcma_pkg::rsp_data_type  rsp_data,
   input  wire                     psel,
   input  wire                     penable,
   input  wire                     pwrite,
   input  wire [2:0]               paddr,
   input  wire [31:0]              pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import gcma_pkg::*;

   localparam logic REG_TAU  = 1'b0;
   localparam logic REG_GRAV = 1'b1;

   logic [19:0] tau_ff;
   logic [20:0] grav_ff;
   cmd_type     cmd;
   status_type  status;

   assign pready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff  <= 20'd8500;
         grav_ff <= 21'd642908;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_TAU:  tau_ff  <= pwdata[19:0];
            REG_GRAV: grav_ff <= pwdata[20:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (paddr[2])
         REG_TAU:  prdata = {12'b0, tau_ff};
         REG_GRAV: prdata = {11'b0, grav_ff};
         default:  prdata = '0;
      endcase
   end

   gcma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gcma_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .tau       (tau_ff),
      .grav      (grav_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

endmodule

`default_nettype wire

// File: sim/gravity_compensated_motion_accel_tb.sv
// Self-checking testbench for gravity_compensated_motion_accel: gravity removal, filtering,
// rotation back to earth frame and saturation, checked against a local fixed-point predictor.
// Depends on gcma_pkg and the gravity_compensated_motion_accel RTL.
`default_nettype none

module gravity_compensated_motion_accel_tb;
   import gcma_pkg::*;

   localparam int ADDR_TAU = 0;
   localparam int ADDR_GRAV = 4;
   localparam longint ONE_Q = 64'sd1 << 30;
   localparam longint HALF_Q = 64'sd1 << 29;
   localparam longint ELEM_LIM = 64'sd1 << 31;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint Q30_MAX = 64'sd1073741824;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   gravity_compensated_motion_accel dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor state and configuration copy
   longint tau_us = 8500;
   longint grav_q16 = 642908;
   longint filt_state[3] = '{0, 0, 0};
   rsp_data_type motion_expect_q[$];

   int error_count = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_left = 0;
   longint cycle_count = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Abort on runaway
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint qmul(longint a, longint b);
      return (a * b + HALF_Q) >>> 30;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Compute the expected motion vectors and advance the filter state
   function automatic rsp_data_type predict_motion(req_data_type d);
      longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint a[3];
      longint r[3][3];
      longint dt, den, diff, num, mag, qv, s;
      bit neg;
      rsp_data_type o;
      w = d.quat_w; x = d.quat_x; y = d.quat_y; z = d.quat_z;
      a[0] = d.accel_x; a[1] = d.accel_y; a[2] = d.accel_z;
      dt = d.step_time_us;
      xx = qmul(x, x); yy = qmul(y, y); zz = qmul(z, z);
      xy = qmul(x, y); xz = qmul(x, z); yz = qmul(y, z);
      wx = qmul(w, x); wy = qmul(w, y); wz = qmul(w, z);
      r[0][0] = ONE_Q - 2 * (yy + zz);
      r[0][1] = 2 * (xy - wz);
      r[0][2] = 2 * (xz + wy);
      r[1][0] = 2 * (xy + wz);
      r[1][1] = ONE_Q - 2 * (xx + zz);
      r[1][2] = 2 * (yz - wx);
      r[2][0] = 2 * (xz - wy);
      r[2][1] = 2 * (yz + wx);
      r[2][2] = ONE_Q - 2 * (xx + yy);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            r[i][j] = clamp(r[i][j], -ELEM_LIM, ELEM_LIM);
      // Zero divisor: hold the filter state
      den = tau_us + dt;
      if (den != 0) begin
         for (int i = 0; i < 3; i++) begin
            diff = a[i] - qmul(r[2][i], grav_q16);
            num = diff * dt + filt_state[i] * tau_us;
            neg = num < 0;
            mag = neg ? -num : num;
            qv = (mag + den / 2) / den;
            if (neg) qv = -qv;
            filt_state[i] = clamp(qv, S32_MIN, S32_MAX);
         end
      end
      o.motion_body_x = 32'(filt_state[0]);
      o.motion_body_y = 32'(filt_state[1]);
      o.motion_body_z = 32'(filt_state[2]);
      s = 0;
      for (int j = 0; j < 3; j++) s += qmul(r[0][j], filt_state[j]);
      o.motion_earth_x = 32'(clamp(s, S32_MIN, S32_MAX));
      s = 0;
      for (int j = 0; j < 3; j++) s += qmul(r[1][j], filt_state[j]);
      o.motion_earth_y = 32'(clamp(s, S32_MIN, S32_MAX));
      s = 0;
      for (int j = 0; j < 3; j++) s += qmul(r[2][j], filt_state[j]);
      o.motion_earth_z = 32'(clamp(s, S32_MIN, S32_MAX));
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      error_count++;
   endtask

   // Receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Check each result transfer against the oldest expectation
   always @(negedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (motion_expect_q.size() == 0) begin
            $display("unexpected result transfer");
            error_count++;
         end else begin
            want = motion_expect_q.pop_front();
            if (rsp_data.motion_body_x !== want.motion_body_x)
               report_mismatch("motion_body_x", rsp_data.motion_body_x, want.motion_body_x);
            if (rsp_data.motion_body_y !== want.motion_body_y)
               report_mismatch("motion_body_y", rsp_data.motion_body_y, want.motion_body_y);
            if (rsp_data.motion_body_z !== want.motion_body_z)
               report_mismatch("motion_body_z", rsp_data.motion_body_z, want.motion_body_z);
            if (rsp_data.motion_earth_x !== want.motion_earth_x)
               report_mismatch("motion_earth_x", rsp_data.motion_earth_x, want.motion_earth_x);
            if (rsp_data.motion_earth_y !== want.motion_earth_y)
               report_mismatch("motion_earth_y", rsp_data.motion_earth_y, want.motion_earth_y);
            if (rsp_data.motion_earth_z !== want.motion_earth_z)
               report_mismatch("motion_earth_z", rsp_data.motion_earth_z, want.motion_earth_z);
         end
      end
   end

   // Offer one item, hold it until the transfer, then record its expectation
   task automatic send_sample(req_data_type d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      motion_expect_q.push_back(predict_motion(d));
   endtask

   // Drain, then write one register with a setup and an access phase
   task automatic write_reg(int addr, logic [31:0] value);
      req_valid <= 1'b0;
      wait (motion_expect_q.size() == 0);
      repeat (8) @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= addr[2:0]; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_TAU) tau_us = value[19:0];
      else grav_q16 = value[20:0];
      @(posedge clock);
   endtask

   function automatic req_data_type make_sample(longint w, longint x, longint y, longint z,
                                                longint ax, longint ay, longint az,
                                                int dt);
      req_data_type d;
      d.quat_w = 32'(w); d.quat_x = 32'(x); d.quat_y = 32'(y); d.quat_z = 32'(z);
      d.accel_x = 32'(ax); d.accel_y = 32'(ay); d.accel_z = 32'(az);
      d.step_time_us = 16'(dt);
      return d;
   endfunction

   function automatic longint rand_q30();
      return longint'($urandom_range(2147483647)) % (2 * Q30_MAX + 1) - Q30_MAX;
   endfunction

   // Mostly a random unit quaternion with plausible samples; sometimes raw noise
   function automatic req_data_type random_sample();
      real v[4];
      real norm;
      longint q[4];
      longint acc[3];
      int dt;
      req_data_type d;
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
         v[i] = (real'($urandom_range(2000000)) - 1000000.0) / 1000000.0;
         norm += v[i] * v[i];
      end
      if (norm < 1.0e-6) begin
         v[0] = 1.0; norm = 1.0;
      end
      norm = $sqrt(norm);
      for (int i = 0; i < 4; i++) q[i] = $rtoi(v[i] / norm * 1073741824.0);
      if ($urandom_range(9) == 0)
         for (int i = 0; i < 4; i++) q[i] = rand_q30();
      for (int i = 0; i < 3; i++)
         acc[i] = ($urandom_range(7) == 0) ? longint'($signed($urandom()))
                  : longint'($urandom_range(2000000)) - 1000000;
      case ($urandom_range(9))
         0: dt = $urandom_range(65535);
         1: dt = 0;
         default: dt = $urandom_range(2000, 500);
      endcase
      return make_sample(q[0], q[1], q[2], q[3], acc[0], acc[1], acc[2], dt);
   endfunction

   // Directed corners: orientations, extreme samples, non-unit quaternions, held filter
   task automatic test_directed();
      send_sample(make_sample(Q30_MAX, 0, 0, 0, 0, 0, 642908, 1000));
      send_sample(make_sample(0, Q30_MAX, 0, 0, 0, 0, -642908, 1000));
      send_sample(make_sample(0, 0, Q30_MAX, 0, 100000, -50000, 0, 1000));
      send_sample(make_sample(0, 0, 0, -Q30_MAX, 1, -1, 642908, 1000));
      send_sample(make_sample(759250125, 759250125, 0, 0, 0, 642908, 0, 2000));
      send_sample(make_sample(Q30_MAX, 0, 0, 0, S32_MAX, S32_MAX, S32_MAX, 65535));
      send_sample(make_sample(Q30_MAX, 0, 0, 0, S32_MIN, S32_MIN, S32_MIN, 65535));
      send_sample(make_sample(Q30_MAX, Q30_MAX, Q30_MAX, Q30_MAX, S32_MAX, S32_MIN, 0, 1));
      send_sample(make_sample(-Q30_MAX, -Q30_MAX, -Q30_MAX, -Q30_MAX, S32_MIN, S32_MAX,
                              S32_MIN, 65535));
      send_sample(make_sample(-Q30_MAX, Q30_MAX, -Q30_MAX, Q30_MAX, 0, 0, 0, 0));
      send_sample(make_sample(0, 0, 0, 0, 12345, -54321, 1000, 500));
      send_sample(make_sample(Q30_MAX, 0, 0, 0, 0, 0, 0, 0));
      // zero tau with zero dt holds the state
      write_reg(ADDR_TAU, 0);
      send_sample(make_sample(Q30_MAX, 0, 0, 0, S32_MAX, 0, 0, 0));
      send_sample(make_sample(0, Q30_MAX, 0, 0, S32_MIN, 5, 0, 0));
      send_sample(make_sample(Q30_MAX, 0, 0, 0, -777777, 333, 642908, 1));
      write_reg(ADDR_TAU, 1000000);
      write_reg(ADDR_GRAV, 2097151);
      send_sample(make_sample(Q30_MAX, 0, 0, 0, S32_MAX, S32_MIN, S32_MAX, 65535));
      send_sample(make_sample(0, 0, Q30_MAX, 0, 0, 0, 0, 1));
      write_reg(ADDR_GRAV, 0);
      send_sample(make_sample(Q30_MAX, 0, 0, 0, 500000, 0, 0, 65535));
      write_reg(ADDR_TAU, 8500);
      write_reg(ADDR_GRAV, 642908);
   endtask

   // Long receiver hold-off with a busy sender so the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_left = 3000;
      repeat (12) send_sample(random_sample());
   endtask

   task automatic test_random(int count, int s_pct, int r_pct, int tau, int grav);
      write_reg(ADDR_TAU, tau);
      write_reg(ADDR_GRAV, grav);
      send_idle_pct = s_pct;
      rcv_idle_pct = r_pct;
      repeat (count) send_sample(random_sample());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(430, 32, 70, 8500, 642908);
      test_random(430, 70, 32, $urandom_range(1000000), $urandom_range(2097151));
      test_random(430, 0, 0, 1000000, 2097151);
      test_random(20, 0, 0, 0, 0);
      req_valid <= 1'b0;
      wait (motion_expect_q.size() == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
